// File: hdl/wrlu_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the write record ring.
package wrlu_pkg;

    localparam int DEPTH    = 16;
    localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int LEN_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int SUM_W    = 20;
    localparam int IDX_W    = 8;
    localparam int SLOT_W   = 6;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_FIND   = 2'd1,
        ACT_TOTAL  = 2'd2,
        ACT_INDEX  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } state_t;

    typedef struct packed {
        action_t               action;
        logic [LEN_W-1:0]      record_length;
        logic [HANDLE_W-1:0]   record_handle;
        logic [SUM_W-1:0]      byte_offset;
        logic [IDX_W-1:0]      record_index;
    } req_t;

    typedef struct packed {
        logic                  found;
        logic [SLOT_W-1:0]     slot;
        logic [HANDLE_W-1:0]   handle_out;
        logic [LEN_W-1:0]      length_out;
        logic [LEN_W-1:0]      byte_within;
        logic [SUM_W-1:0]      bytes_before;
        logic [SUM_W-1:0]      total_bytes;
    } rsp_t;

    typedef struct packed {
        logic [LEN_W-1:0]      len;
        logic [HANDLE_W-1:0]   handle;
    } rec_t;

    typedef struct packed {
        logic                  en;
        logic [PTR_W-1:0]      addr;
        rec_t                  rec;
    } wr_t;

    typedef struct packed {
        logic [SUM_W-1:0]      value;
        logic                  below;
    } alu_res_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
        return (s == PTR_W'(DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

// File: hdl/wrlu_store.sv
`timescale 1ns / 1ps
// Record storage: one length and one handle per ring slot, cleared by reset.
module wrlu_store (
    input  logic                         clk,
    input  logic                         rst_n,
    input  wrlu_pkg::wr_t                wr,
    input  logic [wrlu_pkg::PTR_W-1:0]   rd_addr,
    output wrlu_pkg::rec_t               rd
);
    import wrlu_pkg::*;

    rec_t mem_reg [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                mem_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            mem_reg[wr.addr] <= wr.rec;
        end
    end

    assign rd = mem_reg[rd_addr];

endmodule

// File: hdl/wrlu_alu.sv
`timescale 1ns / 1ps
// Shared adder: saturating accumulate or offset subtract with borrow detect.
module wrlu_alu (
    input  logic [wrlu_pkg::SUM_W-1:0]   acc,
    input  logic [wrlu_pkg::LEN_W-1:0]   len,
    input  logic                         sub,
    output wrlu_pkg::alu_res_t           res
);
    import wrlu_pkg::*;

    logic [SUM_W:0] b_ext;
    logic [SUM_W:0] sum;

    // One adder serves both: subtraction is addition of the complement plus one.
    assign b_ext = sub ? ~{{(SUM_W + 1 - LEN_W){1'b0}}, len}
                       :  {{(SUM_W + 1 - LEN_W){1'b0}}, len};
    assign sum   = {1'b0, acc} + b_ext + {{SUM_W{1'b0}}, sub};

    always_comb
    begin
        res.below = sub & sum[SUM_W];
        if (sub)
        begin
            res.value = sum[SUM_W-1:0];
        end
        else
        begin
            res.value = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
        end
    end

endmodule

// File: hdl/wrlu_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: ring pointers, record walk and the result register.
module wrlu_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_stall,
    input  wrlu_pkg::req_t               req,
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output wrlu_pkg::rsp_t               rsp,
    output wrlu_pkg::wr_t                wr,
    output logic [wrlu_pkg::PTR_W-1:0]   rd_addr,
    input  wrlu_pkg::rec_t               rd,
    output logic [wrlu_pkg::SUM_W-1:0]   alu_acc,
    output logic [wrlu_pkg::LEN_W-1:0]   alu_len,
    output logic                         alu_sub,
    input  wrlu_pkg::alu_res_t           alu_res
);
    import wrlu_pkg::*;

    state_t             state_reg, state_next;
    logic [PTR_W-1:0]   write_slot_reg, write_slot_next;
    logic [PTR_W-1:0]   oldest_slot_reg, oldest_slot_next;
    logic               is_full_reg, is_full_next;
    logic               rsp_valid_reg, rsp_valid_next;
    action_t            act_reg, act_next;
    logic [SUM_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    rsp_t               res_reg, res_next;
    rsp_t               rsp_reg, rsp_next;

    logic [CNT_W-1:0]   count;
    logic               idx_ok;
    logic               walk_done;
    logic               rsp_free;

    always_comb
    begin
        if (is_full_reg)
        begin
            count = CNT_W'(DEPTH);
        end
        else if (write_slot_reg >= oldest_slot_reg)
        begin
            count = CNT_W'(write_slot_reg) - CNT_W'(oldest_slot_reg);
        end
        else
        begin
            count = CNT_W'(write_slot_reg) + CNT_W'(DEPTH) - CNT_W'(oldest_slot_reg);
        end
    end

    assign idx_ok    = (IDX_W + 1)'(req.record_index) < (IDX_W + 1)'(count);
    assign walk_done = (rem_reg == '0) || ((act_reg == ACT_FIND) && alu_res.below);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.action == ACT_APPEND || (req.action == ACT_INDEX && !idx_ok))
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (walk_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        write_slot_next  = write_slot_reg;
        oldest_slot_next = oldest_slot_reg;
        is_full_next     = is_full_reg;
        act_next         = act_reg;
        acc_next         = acc_reg;
        rem_next         = rem_reg;
        ptr_next         = ptr_reg;
        res_next         = res_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg;
        wr               = '0;
        rd_addr          = ptr_reg;
        alu_acc          = acc_reg;
        alu_len          = rd.len;
        alu_sub          = (act_reg == ACT_FIND);

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = write_slot_reg;
                if (req_valid)
                begin
                    act_next = req.action;
                    ptr_next = oldest_slot_reg;
                    rem_next = count;
                    res_next = '0;
                    acc_next = '0;
                    unique case (req.action)
                        ACT_APPEND:
                        begin
                            res_next.found      = is_full_reg;
                            res_next.slot       = SLOT_W'(write_slot_reg);
                            res_next.handle_out = rd.handle;
                            res_next.length_out = rd.len;
                            wr.en               = 1'b1;
                            wr.addr             = write_slot_reg;
                            wr.rec.len          = req.record_length;
                            wr.rec.handle       = req.record_handle;
                            write_slot_next     = next_slot(write_slot_reg);
                            if (is_full_reg)
                            begin
                                oldest_slot_next = write_slot_next;
                            end
                            else if (write_slot_next == oldest_slot_reg)
                            begin
                                is_full_next = 1'b1;
                            end
                        end
                        ACT_FIND:
                        begin
                            acc_next = req.byte_offset;
                        end
                        ACT_TOTAL:
                        begin
                            acc_next = '0;
                        end
                        ACT_INDEX:
                        begin
                            // Only used when the index is in range, so it fits.
                            rem_next = CNT_W'(req.record_index);
                        end
                        default:
                        begin
                            acc_next = '0;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (rem_reg == '0)
                begin
                    case (act_reg)
                        ACT_TOTAL:
                        begin
                            res_next.found       = 1'b1;
                            res_next.total_bytes = acc_reg;
                        end
                        ACT_INDEX:
                        begin
                            res_next.found        = 1'b1;
                            res_next.slot         = SLOT_W'(ptr_reg);
                            res_next.handle_out   = rd.handle;
                            res_next.length_out   = rd.len;
                            res_next.bytes_before = acc_reg;
                        end
                        default:
                        begin
                            res_next = res_reg;
                        end
                    endcase
                end
                else if (act_reg == ACT_FIND && alu_res.below)
                begin
                    // The remaining offset is below this length, so it fits in 16 bits.
                    res_next.found       = 1'b1;
                    res_next.slot        = SLOT_W'(ptr_reg);
                    res_next.handle_out  = rd.handle;
                    res_next.length_out  = rd.len;
                    res_next.byte_within = acc_reg[LEN_W-1:0];
                end
                else
                begin
                    acc_next = alu_res.value;
                    ptr_next = next_slot(ptr_reg);
                    rem_next = rem_reg - 1'b1;
                end
            end
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                end
            end
            default:
            begin
                rd_addr = ptr_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_slot_reg  <= '0;
            oldest_slot_reg <= '0;
            is_full_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            write_slot_reg  <= write_slot_next;
            oldest_slot_reg <= oldest_slot_next;
            is_full_reg     <= is_full_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        ptr_reg <= ptr_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_full_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
        is_full_reg |-> (write_slot_reg == oldest_slot_reg))
        else $error("full ring with write and oldest slots apart");

    a_append_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && req_valid && req.action == ACT_APPEND)
        |=> (write_slot_reg == next_slot($past(write_slot_reg))))
        else $error("append did not advance the write slot");

    a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (rem_reg <= CNT_W'(DEPTH)))
        else $error("walk longer than the ring");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && rsp_free) |=> (state_reg == S_IDLE && rsp_valid_reg))
        else $error("result not handed to the output register");

endmodule

// File: hdl/write_record_ring_with_offset_lookup_unit.sv
`timescale 1ns / 1ps
// Write record ring with byte offset lookup: top level.
//
// Requests arrive on req (req_valid / req_stall) and each gives exactly one
// beat on rsp (rsp_valid / rsp_stall). A beat is taken at a clock edge with
// valid high and stall low. The unit handles one request at a time: req_stall
// is high from the accepting edge until the result has entered the output
// register.
// An append, or a get-by-index past the newest record, skips the walk: it
// goes from the idle state to the emit state and from there into the output
// register. Find, total and get-by-index walk the stored records oldest
// first, one record per cycle through a single shared adder. A walk steps
// over at most the ring depth of 16 records before it ends; the result then
// passes through the emit state into the output register.
// The output register holds its beat while rsp_stall is high; a finished
// result then waits in the sequencer and no new request is taken.
// Reset (rst_n low, asynchronous) empties the ring and clears all stored
// lengths and handles to zero; the unit then stands idle, ready for a request.
module write_record_ring_with_offset_lookup_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  wrlu_pkg::req_t    req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output wrlu_pkg::rsp_t    rsp
);
    import wrlu_pkg::*;

    wr_t                wr;
    logic [PTR_W-1:0]   rd_addr;
    rec_t               rd;
    logic [SUM_W-1:0]   alu_acc;
    logic [LEN_W-1:0]   alu_len;
    logic               alu_sub;
    alu_res_t           alu_res;

    wrlu_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd      (rd)
    );

    wrlu_alu u_alu (
        .acc (alu_acc),
        .len (alu_len),
        .sub (alu_sub),
        .res (alu_res)
    );

    wrlu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .wr        (wr),
        .rd_addr   (rd_addr),
        .rd        (rd),
        .alu_acc   (alu_acc),
        .alu_len   (alu_len),
        .alu_sub   (alu_sub),
        .alu_res   (alu_res)
    );

endmodule

// File: dv/write_record_ring_with_offset_lookup_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the write record ring with offset lookup unit.
module write_record_ring_with_offset_lookup_unit_tb;
    import wrlu_pkg::*;

    localparam int N_RANDOM    = 1000;
    localparam int DRAIN_AT    = 600;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 80;
    localparam int MAX_REPORTS = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    write_record_ring_with_offset_lookup_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted contents of the ring.
    logic [LEN_W-1:0]    ring_len    [DEPTH];
    logic [HANDLE_W-1:0] ring_handle [DEPTH];
    int unsigned         wr_ptr = 0;
    int unsigned         old_ptr = 0;
    bit                  ring_full = 1'b0;

    req_t req_backlog[$];
    rsp_t result_q[$];
    int   n_items;
    int   accepted_cnt = 0;
    int   checked_cnt = 0;
    int   mismatches = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   stall_draw = 0;
    rsp_t want;

    // Shadow of stored lengths, used only to aim offsets and indexes at live records.
    logic [LEN_W-1:0] aim_len [DEPTH];
    int unsigned      aim_wp = 0;
    int unsigned      aim_cnt = 0;

    function automatic int unsigned ring_count();
        if (ring_full)
            return DEPTH;
        return (wr_ptr + DEPTH - old_ptr) % DEPTH;
    endfunction

    function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] a,
                                                  input logic [LEN_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - LEN_W){1'b0}}, b};
        return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    // Works out the beat a request produces and applies its effect on the ring.
    function automatic rsp_t ring_lookup_result(input req_t r);
        rsp_t             o;
        int unsigned      cnt;
        int unsigned      s;
        int unsigned      i;
        logic [SUM_W-1:0] offs;
        logic [SUM_W-1:0] acc;
        o = '0;
        cnt = ring_count();
        s = old_ptr;
        acc = '0;
        case (r.action)
            ACT_APPEND:
            begin
                s = wr_ptr;
                o.found = ring_full;
                o.slot = SLOT_W'(s);
                o.handle_out = ring_handle[s];
                o.length_out = ring_len[s];
                ring_len[s] = r.record_length;
                ring_handle[s] = r.record_handle;
                wr_ptr = (s + 1) % DEPTH;
                if (ring_full)
                    old_ptr = wr_ptr;
                else if (wr_ptr == old_ptr)
                    ring_full = 1'b1;
            end
            ACT_FIND:
            begin
                offs = r.byte_offset;
                for (i = 0; i < cnt; i++)
                begin
                    if (offs < ring_len[s])
                    begin
                        o.found = 1'b1;
                        o.slot = SLOT_W'(s);
                        o.handle_out = ring_handle[s];
                        o.length_out = ring_len[s];
                        o.byte_within = offs[LEN_W-1:0];
                        break;
                    end
                    offs = offs - ring_len[s];
                    s = (s + 1) % DEPTH;
                end
            end
            ACT_TOTAL:
            begin
                for (i = 0; i < cnt; i++)
                begin
                    acc = sat_sum(acc, ring_len[s]);
                    s = (s + 1) % DEPTH;
                end
                o.found = 1'b1;
                o.total_bytes = acc;
            end
            default:
            begin
                if (r.record_index < cnt)
                begin
                    for (i = 0; i < r.record_index; i++)
                    begin
                        acc = sat_sum(acc, ring_len[s]);
                        s = (s + 1) % DEPTH;
                    end
                    o.found = 1'b1;
                    o.slot = SLOT_W'(s);
                    o.handle_out = ring_handle[s];
                    o.length_out = ring_len[s];
                    o.bytes_before = acc;
                end
            end
        endcase
        return o;
    endfunction

    function automatic int unsigned aim_total();
        int unsigned t;
        t = 0;
        for (int k = 0; k < DEPTH; k++)
            t += aim_len[k];
        return t;
    endfunction

    task automatic queue_beat(input action_t a, input logic [LEN_W-1:0] len,
                              input logic [HANDLE_W-1:0] h, input logic [SUM_W-1:0] off,
                              input logic [IDX_W-1:0] idx);
        req_t r;
        r.action = a;
        r.record_length = len;
        r.record_handle = h;
        r.byte_offset = off;
        r.record_index = idx;
        req_backlog.push_back(r);
        if (a == ACT_APPEND)
        begin
            aim_len[aim_wp] = len;
            aim_wp = (aim_wp + 1) % DEPTH;
            if (aim_cnt < DEPTH)
                aim_cnt++;
        end
    endtask

    task automatic queue_random_beat();
        int unsigned      pick;
        int unsigned      kind;
        logic [LEN_W-1:0] len;
        logic [SUM_W-1:0] off;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 9);
        len = LEN_W'($urandom);
        off = SUM_W'($urandom);
        idx = IDX_W'($urandom);
        if (pick < 35)
        begin
            if (kind == 0)
                len = '0;
            else if (kind == 1)
                len = '1;
            else if (kind < 6)
                len = LEN_W'($urandom_range(0, 15));
            else if (kind < 8)
                len = LEN_W'($urandom_range(0, 1023));
            queue_beat(ACT_APPEND, len, $urandom, off, idx);
        end
        else if (pick < 65)
        begin
            // Mostly offsets that land inside, or just past, the stored bytes.
            if (kind < 8)
                off = SUM_W'($urandom_range(0, aim_total()));
            queue_beat(ACT_FIND, len, $urandom, off, idx);
        end
        else if (pick < 75)
            queue_beat(ACT_TOTAL, len, $urandom, off, idx);
        else
        begin
            if (kind < 8)
                idx = IDX_W'($urandom_range(0, aim_cnt));
            queue_beat(ACT_INDEX, len, $urandom, off, idx);
        end
    endtask

    // Driver: offers backlog items, predicting each accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            gap_left <= 0;
            accepted_cnt <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                result_q.push_back(ring_lookup_result(req));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (req_valid && req_stall)
                req_valid <= 1'b1;
            else if (gap_left != 0)
            begin
                req_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (req_backlog.size() != 0 &&
                     !((accepted_cnt + int'(req_valid && !req_stall)) == DRAIN_AT &&
                       checked_cnt != DRAIN_AT))
            begin
                req <= req_backlog.pop_front();
                req_valid <= 1'b1;
                gap_left <= (((accepted_cnt / 50) % 4) == 3) ? 0 : $urandom_range(0, 5);
            end
            else
                req_valid <= 1'b0;
        end
    end

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s expected %0h, actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left <= 0;
            checked_cnt <= 0;
        end
        else if (rsp_valid && !rsp_stall)
        begin
            checked_cnt <= checked_cnt + 1;
            if (result_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual %0h", $time, rsp);
            end
            else
            begin
                want = result_q.pop_front();
                compare_field("found", want.found, rsp.found);
                compare_field("slot", want.slot, rsp.slot);
                compare_field("handle_out", want.handle_out, rsp.handle_out);
                compare_field("length_out", want.length_out, rsp.length_out);
                compare_field("byte_within", want.byte_within, rsp.byte_within);
                compare_field("bytes_before", want.bytes_before, rsp.bytes_before);
                compare_field("total_bytes", want.total_bytes, rsp.total_bytes);
            end
            // One long hold-off lets the sender back up behind a full unit.
            if (checked_cnt + 1 == HOLD_AT)
            begin
                rsp_stall <= 1'b1;
                stall_left <= HOLD_CYCLES - 1;
            end
            else if (((checked_cnt / 50) % 4) == 1)
            begin
                rsp_stall <= 1'b0;
                stall_left <= 0;
            end
            else
            begin
                stall_draw = int'($urandom_range(0, 5));
                rsp_stall <= (stall_draw != 0);
                stall_left <= (stall_draw != 0) ? stall_draw - 1 : 0;
            end
        end
        else if (stall_left != 0)
        begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
            rsp_stall <= 1'b0;
    end

    initial
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            ring_len[k] = '0;
            ring_handle[k] = '0;
            aim_len[k] = '0;
        end

        // Lookups on an empty ring: find and get-by-index report nothing found, total reports zero bytes.
        queue_beat(ACT_TOTAL, '1, '1, '1, '1);
        queue_beat(ACT_FIND, '0, '0, '0, '0);
        queue_beat(ACT_INDEX, '0, '0, '0, '0);
        queue_beat(ACT_APPEND, 16'd0, 32'h0000_0000, '0, '0);
        queue_beat(ACT_APPEND, 16'hffff, 32'hffff_ffff, '1, '1);
        queue_beat(ACT_APPEND, 16'd1, 32'h1234_5678, '0, '0);
        queue_beat(ACT_APPEND, 16'd0, 32'ha5a5_a5a5, '0, '0);
        queue_beat(ACT_APPEND, 16'd3, 32'h5a5a_5a5a, '0, '0);
        // Finds must step over the zero-length records.
        queue_beat(ACT_FIND, '0, '0, 20'd0, '0);
        queue_beat(ACT_FIND, '0, '0, 20'd65534, '0);
        queue_beat(ACT_FIND, '0, '0, 20'd65535, '0);
        queue_beat(ACT_FIND, '0, '0, 20'd65536, '0);
        queue_beat(ACT_FIND, '0, '0, 20'd65538, '0);
        queue_beat(ACT_FIND, '0, '0, 20'd65539, '0);
        queue_beat(ACT_FIND, '1, '1, 20'hfffff, '1);
        queue_beat(ACT_INDEX, '0, '0, '0, 8'd0);
        queue_beat(ACT_INDEX, '0, '0, '0, 8'd4);
        queue_beat(ACT_INDEX, '0, '0, '0, 8'd5);
        queue_beat(ACT_INDEX, '1, '1, '1, 8'd255);
        queue_beat(ACT_TOTAL, '0, '0, '0, '0);

        for (int k = 0; k < N_RANDOM; k++)
            queue_random_beat();
        n_items = req_backlog.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (accepted_cnt == n_items && checked_cnt == n_items);
        repeat (40) @(posedge clk);
        if (result_q.size() != 0)
        begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time, result_q.size());
        end
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
